// ===== sv/i2cmts_pkg.sv =====
// Package for the I2C master transfer sequencer.
// Holds the function and action codes and the transfer payload types.
// No dependencies.
`timescale 1ns / 1ps

package i2cmts_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 5;
  localparam int unsigned LoadW  = 4;

  typedef enum logic [1:0] {
    FUNC_LOAD     = 2'd0,
    FUNC_START_WR = 2'd1,
    FUNC_START_RD = 2'd2,
    FUNC_DONE     = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ACT_START = 3'd0,
    ACT_TX    = 3'd1,
    ACT_STOP  = 3'd2,
    ACT_RCEN  = 3'd3,
    ACT_ACK   = 3'd4,
    ACT_OK    = 3'd5,
    ACT_FAIL  = 3'd6
  } action_e;

  typedef struct packed {
    func_e             func;
    logic [LoadW-1:0]  load_index;
    logic [ByteW-1:0]  load_value;
    logic [CountW-1:0] byte_count;
    logic              nack_seen;
    logic [ByteW-1:0]  received_byte;
  } req_t;

  typedef struct packed {
    action_e          action;
    logic [ByteW-1:0] tx_value;
    logic             ack_level;
    logic [LoadW-1:0] rx_position;
    logic [ByteW-1:0] rx_value;
  } rsp_t;

endpackage

// ===== sv/i2cmts_if.sv =====
// Valid/ready channel interfaces for the I2C master transfer sequencer.
// Depends on i2cmts_pkg for the request and response payload types.
`timescale 1ns / 1ps

interface i2cmts_req_if import i2cmts_pkg::*;;
  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface i2cmts_rsp_if import i2cmts_pkg::*;;
  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/i2cmts_top.sv =====
// Top level of the I2C master transfer sequencer: input register, sequencer
// state machine, byte buffer and result register.
// Depends on i2cmts_pkg, i2cmts_if.sv and i2cmts_store.
`timescale 1ns / 1ps

// The sequencer accepts one transfer on req_i in every clock cycle while the
// input register is not stalled, and presents its result, if it has one, on
// rsp_o from the result register: the accepting edge loads the input register
// and a later advance loads the result register. A held result stalls the
// input only once the input register is also full. The byte buffer is read
// ahead at the position that the next bus-done event will transmit, so that
// read does not add latency. A start item with a byte count below 2 or above
// BUF_DEPTH returns a failure at once. Write the retry limit only while no
// transaction is running.

module i2c_master_transfer_sequencer_top import i2cmts_pkg::*; #(
  parameter int unsigned BUF_DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_wdata_i,
  i2cmts_req_if.sink          req_i,
  i2cmts_rsp_if.source        rsp_o
);

  localparam int unsigned IdxW = $clog2(BUF_DEPTH);

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_START_WAIT,
    PH_ADDR_WAIT,
    PH_WDATA_WAIT,
    PH_RETRY_WAIT,
    PH_RX_WAIT,
    PH_ACKRX_WAIT,
    PH_OK_STOP,
    PH_FAIL_STOP
  } phase_e;

  phase_e            phase_q, phase_d;
  logic              is_read_q, is_read_d;
  logic [CountW-1:0] position_q, position_d;
  logic [CountW-1:0] total_bytes_q, total_bytes_d;
  logic [2:0]        retries_q, retries_d;
  logic [2:0]        retry_limit_q;
  logic              s_valid_q, s_valid_d;
  req_t              s_q;
  logic              out_valid_q, out_valid_d;
  rsp_t              out_q, out_d;

  logic              advance;
  logic              wr_en;
  logic [IdxW-1:0]   wr_addr;
  logic [ByteW-1:0]  wr_data;
  logic [IdxW-1:0]   rd_addr;
  logic [ByteW-1:0]  rd_data;
  logic              last_rx;

  assign advance   = s_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !s_valid_q || advance;
  assign s_valid_d = req_i.valid ? 1'b1 : (advance ? 1'b0 : s_valid_q);
  assign last_rx   = ({1'b0, position_q} + (CountW+1)'(1)) >= {1'b0, total_bytes_q};

  always_comb begin
    phase_d       = phase_q;
    is_read_d     = is_read_q;
    position_d    = position_q;
    total_bytes_d = total_bytes_q;
    retries_d     = retries_q;
    out_valid_d   = out_valid_q && !rsp_o.ready;
    out_d         = out_q;
    wr_en         = 1'b0;
    wr_addr       = IdxW'(s_q.load_index);
    wr_data       = s_q.load_value;
    if (advance) begin
      out_valid_d = 1'b0;
      out_d       = '0;
      case (s_q.func)
        FUNC_LOAD: begin
          wr_en = (32'(s_q.load_index) < BUF_DEPTH);
        end
        FUNC_START_WR, FUNC_START_RD: begin
          if (phase_q == PH_IDLE) begin
            out_valid_d = 1'b1;
            if ((s_q.byte_count < CountW'(2)) || (32'(s_q.byte_count) > BUF_DEPTH)) begin
              out_d.action = ACT_FAIL;
            end else begin
              is_read_d     = (s_q.func == FUNC_START_RD);
              total_bytes_d = s_q.byte_count;
              position_d    = '0;
              retries_d     = '0;
              phase_d       = PH_START_WAIT;
              out_d.action  = ACT_START;
            end
          end
        end
        default: begin
          out_valid_d = 1'b1;
          case (phase_q)
            PH_START_WAIT: begin
              position_d     = CountW'(1);
              phase_d        = PH_ADDR_WAIT;
              out_d.action   = ACT_TX;
              out_d.tx_value = rd_data;
            end
            PH_ADDR_WAIT: begin
              if (s_q.nack_seen) begin
                if (retries_q < retry_limit_q) begin
                  retries_d = retries_q + 3'd1;
                  phase_d   = PH_RETRY_WAIT;
                end else begin
                  phase_d = PH_FAIL_STOP;
                end
                out_d.action = ACT_STOP;
              end else begin
                retries_d = '0;
                if (is_read_q) begin
                  phase_d      = PH_RX_WAIT;
                  out_d.action = ACT_RCEN;
                end else begin
                  position_d     = position_q + CountW'(1);
                  phase_d        = PH_WDATA_WAIT;
                  out_d.action   = ACT_TX;
                  out_d.tx_value = rd_data;
                end
              end
            end
            PH_WDATA_WAIT: begin
              if (s_q.nack_seen) begin
                phase_d      = PH_FAIL_STOP;
                out_d.action = ACT_STOP;
              end else if (position_q >= total_bytes_q) begin
                phase_d      = PH_OK_STOP;
                out_d.action = ACT_STOP;
              end else begin
                position_d     = position_q + CountW'(1);
                out_d.action   = ACT_TX;
                out_d.tx_value = rd_data;
              end
            end
            PH_RETRY_WAIT: begin
              position_d   = '0;
              phase_d      = PH_START_WAIT;
              out_d.action = ACT_START;
            end
            PH_RX_WAIT: begin
              wr_en             = (32'(position_q) < BUF_DEPTH);
              wr_addr           = IdxW'(position_q);
              wr_data           = s_q.received_byte;
              position_d        = position_q + CountW'(1);
              phase_d           = PH_ACKRX_WAIT;
              out_d.action      = ACT_ACK;
              out_d.ack_level   = last_rx;
              out_d.rx_position = position_q[LoadW-1:0];
              out_d.rx_value    = s_q.received_byte;
            end
            PH_ACKRX_WAIT: begin
              if (position_q >= total_bytes_q) begin
                phase_d      = PH_OK_STOP;
                out_d.action = ACT_STOP;
              end else begin
                phase_d      = PH_RX_WAIT;
                out_d.action = ACT_RCEN;
              end
            end
            PH_OK_STOP: begin
              phase_d      = PH_IDLE;
              out_d.action = ACT_OK;
            end
            PH_FAIL_STOP: begin
              phase_d      = PH_IDLE;
              out_d.action = ACT_FAIL;
            end
            default: begin
              phase_d     = PH_IDLE;
              out_valid_d = 1'b0;
            end
          endcase
        end
      endcase
    end
  end

  assign rd_addr = (phase_d == PH_START_WAIT) ? '0 : IdxW'(position_d);

  i2cmts_store #(
    .DEPTH(BUF_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(wr_addr),
    .wdata_i(wr_data),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_IDLE;
      is_read_q     <= 1'b0;
      position_q    <= '0;
      total_bytes_q <= '0;
      retries_q     <= '0;
      retry_limit_q <= 3'd5;
      s_valid_q     <= 1'b0;
      s_q           <= '0;
      out_valid_q   <= 1'b0;
      out_q         <= '0;
    end else begin
      phase_q       <= phase_d;
      is_read_q     <= is_read_d;
      position_q    <= position_d;
      total_bytes_q <= total_bytes_d;
      retries_q     <= retries_d;
      s_valid_q     <= s_valid_d;
      out_valid_q   <= out_valid_d;
      out_q         <= out_d;
      if (cfg_we_i) begin
        retry_limit_q <= cfg_wdata_i;
      end
      if (req_i.valid && req_i.ready) begin
        s_q <= req_i.data;
      end
    end
  end

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_q;

`ifndef SYNTHESIS
  a_tx_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.action == ACT_TX)) |->
    ((phase_q == PH_ADDR_WAIT) || (phase_q == PH_WDATA_WAIT)))
    else $error("Transmit result held outside a transmit wait phase.");

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PH_IDLE) |-> (position_q <= total_bytes_q))
    else $error("Buffer position ran past the transaction length.");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_valid_q && !advance) |=> ($stable(phase_q) && $stable(position_q)))
    else $error("Sequencer state changed while the input register was stalled.");
`endif

endmodule

// ===== sv/i2cmts_store.sv =====
// Byte buffer of the I2C master transfer sequencer.
// One write port and one registered read port with write-to-read forwarding.
// Depends on i2cmts_pkg for the byte width.
`timescale 1ns / 1ps

module i2cmts_store import i2cmts_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [ByteW-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [ByteW-1:0]         rdata_o
);

  logic [ByteW-1:0] mem [DEPTH];
  logic [ByteW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
